@@ rtl/s_expression_tokenizer_macros.svh @@
// ----------------------------------------------------------------------------
// s_expression_tokenizer_macros
// assertion macros used by the tokenizer checker
// ----------------------------------------------------------------------------
`ifndef S_EXPRESSION_TOKENIZER_MACROS_SVH
`define S_EXPRESSION_TOKENIZER_MACROS_SVH

// plain clocked property, off while reset is asserted
`define SXT_ASSERT(lbl, clk, rst_n, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// a stalled transfer keeps valid high and its payload unchanged
`define SXT_ASSERT_HOLD(lbl, clk, rst_n, vld, rdy, pay, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) \
		((vld) && !(rdy) |=> (vld) && $stable(pay))) else $error(msg);

`endif

@@ rtl/sxt_pkg.sv @@
// ----------------------------------------------------------------------------
// sxt_pkg
// types, constants and helper functions of the s-expression tokenizer
// ----------------------------------------------------------------------------
package sxt_pkg;

	localparam int POS_BITS  = 16;
	localparam int OUT_BITS  = 16;
	localparam int CHAR_BITS = 16;
	localparam int WIDE_BITS = (POS_BITS + 1 > OUT_BITS) ? POS_BITS + 1 : OUT_BITS + 1;

	localparam int QUEUE_DEPTH = 4;
	localparam int QPTR_BITS   = $clog2(QUEUE_DEPTH);
	localparam int MAX_RES     = 3;

	localparam int OUT_TDATA_BITS = 56;
	localparam int OUT_TUSER_BITS = 4;

	typedef logic [POS_BITS-1:0]  pos_t;
	typedef logic [WIDE_BITS-1:0] wide_t;
	typedef logic [OUT_BITS-1:0]  opos_t;
	typedef logic [CHAR_BITS-1:0] char_t;

	localparam pos_t  POS_MAX = {POS_BITS{1'b1}};
	localparam wide_t OUT_MAX = wide_t'({OUT_BITS{1'b1}});

	localparam char_t CH_LPAREN  = 16'h0028;
	localparam char_t CH_RPAREN  = 16'h0029;
	localparam char_t CH_QUOTE   = 16'h0022;
	localparam char_t CH_BSLASH  = 16'h005C;
	localparam char_t CH_LOWER_N = 16'h006E;
	localparam char_t CH_NEWLINE = 16'h000A;

	typedef enum logic [2:0] {
		MODE_IDLE   = 3'd0,
		MODE_IDENT  = 3'd1,
		MODE_STRING = 3'd2,
		MODE_ESCAPE = 3'd3,
		MODE_ERROR  = 3'd4
	} lex_mode_t;

	typedef enum logic [2:0] {
		KIND_OPEN   = 3'd0,
		KIND_CLOSE  = 3'd1,
		KIND_STRING = 3'd2,
		KIND_IDENT  = 3'd3,
		KIND_ERROR  = 3'd4
	} tok_kind_t;

	typedef enum logic [1:0] {
		ERR_NONE     = 2'd0,
		ERR_ESCAPE   = 2'd1,
		ERR_UNCLOSED = 2'd2
	} err_code_t;

	typedef struct packed {
		tok_kind_t kind;
		char_t     text;
		logic      char_valid;
		logic      first;
		logic      done;
		err_code_t err;
		opos_t     line;
		opos_t     column;
	} tok_res_t;

	// all results caused by one input transfer
	typedef struct packed {
		tok_res_t [MAX_RES-1:0] res;
		logic [1:0]             cnt;
	} bundle_t;

	function automatic logic is_space(char_t c);
		return c inside {16'h0020, [16'h0009:16'h000D], 16'h0085, 16'h00A0, 16'h1680,
			[16'h2000:16'h200A], 16'h2028, 16'h2029, 16'h202F, 16'h205F, 16'h3000};
	endfunction

	function automatic pos_t sat_inc(pos_t v);
		return (v == POS_MAX) ? v : v + pos_t'(1);
	endfunction

	function automatic opos_t clip_out(wide_t v);
		return (v > OUT_MAX) ? OUT_MAX[OUT_BITS-1:0] : v[OUT_BITS-1:0];
	endfunction

	function automatic opos_t column_of(pos_t pos, pos_t line_start);
		pos_t d;
		d = (pos >= line_start) ? pos - line_start : '0;
		return clip_out(wide_t'(d) + wide_t'(1));
	endfunction

	function automatic tok_res_t make_res(tok_kind_t kind, char_t text, logic cv,
		logic first, logic done, err_code_t err, opos_t line, opos_t column);
		tok_res_t r;
		r.kind       = kind;
		r.text       = cv ? text : '0;
		r.char_valid = cv;
		r.first      = first;
		r.done       = done;
		r.err        = err;
		r.line       = line;
		r.column     = column;
		return r;
	endfunction

endpackage

@@ rtl/sxt_front.sv @@
// ----------------------------------------------------------------------------
// sxt_front
// classifies each character, tracks lexer mode and positions, and builds
// the bundle of results that one input transfer causes
// ----------------------------------------------------------------------------
module sxt_front import sxt_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    s_tvalid,
	output logic    s_tready,
	input  char_t   s_tdata,   // char_in
	input  logic    s_tuser,   // has_char
	input  logic    s_tlast,   // expr_end
	input  logic    q_full,
	output logic    q_push,
	output bundle_t q_data
);

	lex_mode_t mode_q, mode_c, mode_d;
	pos_t      char_index_q, char_index_d;
	pos_t      line_count_q, line_count_d;
	pos_t      line_start_q, line_start_d;
	opos_t     ts_line_q, ts_line_d;
	opos_t     ts_col_q, ts_col_d;

	logic  accept;
	logic  ch_space, ch_paren, ch_delim, esc_ok, do_idle;
	opos_t col_here, line_here;

	assign s_tready = !q_full;
	assign accept   = s_tvalid && s_tready;

	assign ch_space  = is_space(s_tdata);
	assign ch_paren  = (s_tdata == CH_LPAREN) || (s_tdata == CH_RPAREN);
	assign ch_delim  = ch_space || ch_paren;
	assign esc_ok    = (s_tdata == CH_QUOTE) || (s_tdata == CH_BSLASH) ||
		(s_tdata == CH_LOWER_N);
	assign col_here  = column_of(char_index_q, line_start_q);
	assign line_here = clip_out(wide_t'(line_count_q));

	// idle handling runs between tokens and on the delimiter that ends an identifier
	assign do_idle = s_tuser && ((mode_q == MODE_IDLE) || ((mode_q == MODE_IDENT) && ch_delim));

	// next state
	always_comb begin
		mode_c = mode_q;
		if (s_tuser) begin
			case (mode_q)
				MODE_IDLE: begin
					if (!ch_delim) mode_c = (s_tdata == CH_QUOTE) ? MODE_STRING : MODE_IDENT;
				end
				MODE_IDENT: begin
					if (ch_delim) mode_c = MODE_IDLE;
				end
				MODE_STRING: begin
					if (s_tdata == CH_BSLASH) mode_c = MODE_ESCAPE;
					else if (s_tdata == CH_QUOTE) mode_c = MODE_IDLE;
				end
				MODE_ESCAPE: begin
					mode_c = esc_ok ? MODE_STRING : MODE_ERROR;
				end
				MODE_ERROR: begin
					mode_c = MODE_ERROR;
				end
				default: begin
					mode_c = MODE_IDLE;
				end
			endcase
		end
		mode_d = s_tlast ? MODE_IDLE : mode_c;
	end

	// results and position updates
	always_comb begin
		logic [1:0] n;
		n            = 2'd0;
		q_data       = '0;
		ts_line_d    = ts_line_q;
		ts_col_d     = ts_col_q;
		line_count_d = line_count_q;
		line_start_d = line_start_q;
		char_index_d = char_index_q;

		if (s_tuser && (mode_q == MODE_IDENT)) begin
			if (ch_delim) begin
				q_data.res[n] = make_res(KIND_IDENT, '0, 1'b0, 1'b0, 1'b1, ERR_NONE,
					ts_line_q, ts_col_q);
			end else begin
				q_data.res[n] = make_res(KIND_IDENT, s_tdata, 1'b1, 1'b0, 1'b0, ERR_NONE,
					ts_line_q, ts_col_q);
			end
			n = n + 2'd1;
		end

		if (do_idle) begin
			if (ch_space) begin
				if (s_tdata == CH_NEWLINE) begin
					line_count_d = sat_inc(line_count_q);
					line_start_d = sat_inc(char_index_q);
				end
			end else begin
				ts_line_d = line_here;
				ts_col_d  = col_here;
				if (ch_paren) begin
					q_data.res[n] = make_res((s_tdata == CH_LPAREN) ? KIND_OPEN : KIND_CLOSE,
						s_tdata, 1'b1, 1'b1, 1'b1, ERR_NONE, line_here, col_here);
				end else if (s_tdata == CH_QUOTE) begin
					q_data.res[n] = make_res(KIND_STRING, '0, 1'b0, 1'b1, 1'b0, ERR_NONE,
						line_here, col_here);
				end else begin
					q_data.res[n] = make_res(KIND_IDENT, s_tdata, 1'b1, 1'b1, 1'b0, ERR_NONE,
						line_here, col_here);
				end
				n = n + 2'd1;
			end
		end

		if (s_tuser && (mode_q == MODE_STRING)) begin
			if (s_tdata == CH_QUOTE) begin
				q_data.res[n] = make_res(KIND_STRING, '0, 1'b0, 1'b0, 1'b1, ERR_NONE,
					ts_line_q, ts_col_q);
				n = n + 2'd1;
			end else if (s_tdata != CH_BSLASH) begin
				q_data.res[n] = make_res(KIND_STRING, s_tdata, 1'b1, 1'b0, 1'b0, ERR_NONE,
					ts_line_q, ts_col_q);
				n = n + 2'd1;
			end
		end

		if (s_tuser && (mode_q == MODE_ESCAPE)) begin
			if (esc_ok) begin
				q_data.res[n] = make_res(KIND_STRING,
					(s_tdata == CH_LOWER_N) ? CH_NEWLINE : s_tdata,
					1'b1, 1'b0, 1'b0, ERR_NONE, ts_line_q, ts_col_q);
			end else begin
				// bad escape is reported where the offending character sits
				q_data.res[n] = make_res(KIND_ERROR, '0, 1'b0, 1'b1, 1'b1, ERR_ESCAPE,
					line_here, col_here);
			end
			n = n + 2'd1;
		end

		if (s_tuser) char_index_d = sat_inc(char_index_q);

		if (s_tlast) begin
			if (mode_c == MODE_IDENT) begin
				q_data.res[n] = make_res(KIND_IDENT, '0, 1'b0, 1'b0, 1'b1, ERR_NONE,
					ts_line_d, ts_col_d);
				n = n + 2'd1;
			end else if ((mode_c == MODE_STRING) || (mode_c == MODE_ESCAPE)) begin
				q_data.res[n] = make_res(KIND_ERROR, '0, 1'b0, 1'b1, 1'b1, ERR_UNCLOSED,
					ts_line_d, ts_col_d);
				n = n + 2'd1;
			end
			char_index_d = '0;
			line_count_d = '0;
			line_start_d = '0;
			ts_line_d    = '0;
			ts_col_d     = opos_t'(1);
		end

		q_data.cnt = n;
	end

	assign q_push = accept && (q_data.cnt != 2'd0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q       <= MODE_IDLE;
			char_index_q <= '0;
			line_count_q <= '0;
			line_start_q <= '0;
			ts_line_q    <= '0;
			ts_col_q     <= opos_t'(1);
		end else if (accept) begin
			mode_q       <= mode_d;
			char_index_q <= char_index_d;
			line_count_q <= line_count_d;
			line_start_q <= line_start_d;
			ts_line_q    <= ts_line_d;
			ts_col_q     <= ts_col_d;
		end
	end

endmodule

@@ rtl/sxt_queue.sv @@
// ----------------------------------------------------------------------------
// sxt_queue
// short queue of result bundles between front and back
// ----------------------------------------------------------------------------
module sxt_queue import sxt_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    push,
	input  bundle_t wr_data,
	output logic    full,
	input  logic    pop,
	output bundle_t rd_data,
	output logic    empty
);

	bundle_t              entry_q [QUEUE_DEPTH];
	logic [QPTR_BITS-1:0] wr_ptr_q, rd_ptr_q;
	logic [QPTR_BITS:0]   count_q;
	logic                 do_push, do_pop;

	assign full    = (count_q == (QPTR_BITS+1)'(QUEUE_DEPTH));
	assign empty   = (count_q == '0);
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;
	assign rd_data = entry_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_push) entry_q[wr_ptr_q] <= wr_data;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == QPTR_BITS'(QUEUE_DEPTH-1)) ? '0 :
					wr_ptr_q + QPTR_BITS'(1);
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == QPTR_BITS'(QUEUE_DEPTH-1)) ? '0 :
					rd_ptr_q + QPTR_BITS'(1);
			end
			if (do_push && !do_pop) count_q <= count_q + (QPTR_BITS+1)'(1);
			else if (do_pop && !do_push) count_q <= count_q - (QPTR_BITS+1)'(1);
		end
	end

endmodule

@@ rtl/sxt_back.sv @@
// ----------------------------------------------------------------------------
// sxt_back
// walks the head bundle one result per cycle into the output register while the output is not stalled
// ----------------------------------------------------------------------------
module sxt_back import sxt_pkg::*; (
	input  logic                      clk,
	input  logic                      arst_n,
	input  bundle_t                   head,
	input  logic                      empty,
	output logic                      pop,
	output logic                      m_tvalid,
	input  logic                      m_tready,
	output logic [OUT_TDATA_BITS-1:0] m_tdata,  // text_char, token_first, token_done,
	                                            // error_code, line_no, column_no
	output logic [OUT_TUSER_BITS-1:0] m_tuser,  // token_kind, char_valid
	output logic                      m_tlast   // run_last
);

	logic [1:0] idx_q;
	logic       valid_q;
	tok_res_t   out_q;
	logic       last_q;
	logic       load, at_last;

	assign load    = !empty && (!valid_q || m_tready);
	assign at_last = (idx_q == (head.cnt - 2'd1));
	assign pop     = load && at_last;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			idx_q   <= 2'd0;
		end else begin
			if (load) begin
				valid_q <= 1'b1;
				idx_q   <= at_last ? 2'd0 : idx_q + 2'd1;
			end else if (m_tready) begin
				valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			out_q  <= head.res[idx_q];
			last_q <= at_last;
		end
	end

	assign m_tvalid = valid_q;
	assign m_tdata  = {4'b0, out_q.column, out_q.line, out_q.err, out_q.done, out_q.first,
		out_q.text};
	assign m_tuser  = {out_q.char_valid, out_q.kind};
	assign m_tlast  = last_q;

endmodule

@@ rtl/s_expression_tokenizer.sv @@
// ----------------------------------------------------------------------------
// s_expression_tokenizer
// streaming tokenizer for s-expression text, one utf-16 code unit a transfer
// ----------------------------------------------------------------------------
// channel  dir  tdata                               tuser                  tlast
// s_       in   char_in                             has_char               expr_end
// m_       out  text_char first done err line col   token_kind char_valid  run_last
//
// one input transfer a cycle while the queue is not full; the front decides all
// results of a character in that cycle and queues them as one bundle (queue of four
// bundles); the back emits one result a cycle while the output is not stalled and
// pops a bundle with its last result; the queue and the output are both registered
// reset clears mode, positions, queue and output valid; no clearing pass
// ----------------------------------------------------------------------------
module s_expression_tokenizer import sxt_pkg::*; (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      s_tvalid,
	output logic                      s_tready,
	input  logic [15:0]               s_tdata,   // char_in
	input  logic                      s_tuser,   // has_char
	input  logic                      s_tlast,   // expr_end
	output logic                      m_tvalid,
	input  logic                      m_tready,
	output logic [OUT_TDATA_BITS-1:0] m_tdata,   // text_char[15:0], token_first[16],
	                                             // token_done[17], error_code[19:18],
	                                             // line_no[35:20], column_no[51:36]
	output logic [OUT_TUSER_BITS-1:0] m_tuser,   // token_kind[2:0], char_valid[3]
	output logic                      m_tlast    // run_last
);

	logic    q_push, q_full, q_pop, q_empty;
	bundle_t q_wr, q_rd;

	sxt_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.s_tlast  (s_tlast),
		.q_full   (q_full),
		.q_push   (q_push),
		.q_data   (q_wr)
	);

	sxt_queue u_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (q_push),
		.wr_data (q_wr),
		.full    (q_full),
		.pop     (q_pop),
		.rd_data (q_rd),
		.empty   (q_empty)
	);

	sxt_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.head     (q_rd),
		.empty    (q_empty),
		.pop      (q_pop),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.m_tlast  (m_tlast)
	);

endmodule

@@ rtl/sxt_checker.sv @@
// ----------------------------------------------------------------------------
// sxt_checker
// port-level checks on the tokenizer result stream
// ----------------------------------------------------------------------------
`include "s_expression_tokenizer_macros.svh"

module sxt_checker import sxt_pkg::*; (
	input logic                      clk,
	input logic                      arst_n,
	input logic                      m_tvalid,
	input logic                      m_tready,
	input logic [OUT_TDATA_BITS-1:0] m_tdata,
	input logic [OUT_TUSER_BITS-1:0] m_tuser,
	input logic                      m_tlast
);

	`SXT_ASSERT(a_kind_range, clk, arst_n, m_tvalid |-> (m_tuser[2:0] <= KIND_ERROR), "token kind out of range")

	// an error is a whole token and closes the run of its input
	`SXT_ASSERT(a_error_frame, clk, arst_n, m_tvalid && (m_tuser[2:0] == KIND_ERROR) |-> m_tdata[16] && m_tdata[17] && !m_tuser[3] && m_tlast && (m_tdata[19:18] != ERR_NONE), "malformed error result")

	`SXT_ASSERT(a_text_and_column, clk, arst_n, m_tvalid |-> (m_tuser[3] || (m_tdata[15:0] == '0)) && (m_tdata[51:36] != '0), "bad text or column")

	`SXT_ASSERT_HOLD(a_out_hold, clk, arst_n, m_tvalid, m_tready, {m_tdata, m_tuser, m_tlast}, "stalled transfer changed")

endmodule

bind s_expression_tokenizer sxt_checker u_sxt_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata),
	.m_tuser  (m_tuser),
	.m_tlast  (m_tlast)
);

@@ verif/s_expression_tokenizer_check.sv @@
// ----------------------------------------------------------------------------
// s_expression_tokenizer_check
// watches both streams of the tokenizer, predicts the token results of every
// accepted input transfer and compares each output transfer field by field
// ----------------------------------------------------------------------------
module s_expression_tokenizer_check import sxt_pkg::*; (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      s_tvalid,
	input  logic                      s_tready,
	input  logic [15:0]               s_tdata,   // char_in
	input  logic                      s_tuser,   // has_char
	input  logic                      s_tlast,   // expr_end
	input  logic                      m_tvalid,
	input  logic                      m_tready,
	input  logic [OUT_TDATA_BITS-1:0] m_tdata,   // text_char, first, done, err, line, col
	input  logic [OUT_TUSER_BITS-1:0] m_tuser,   // token_kind, char_valid
	input  logic                      m_tlast,   // run_last
	output int                        mismatches,
	output int                        backlog
);
	timeunit 1ns;
	timeprecision 1ps;

	typedef struct packed {
		tok_res_t res;
		logic     last;
	} token_beat_t;

	token_beat_t awaited[$];
	tok_res_t    batch [0:MAX_RES-1];
	int          batch_n;
	int          fail_cnt = 0;
	int          results_seen = 0;

	// lexer state of the predictor
	lex_mode_t mode;
	pos_t      char_pos;
	pos_t      lines;
	pos_t      line_base;
	opos_t     start_line;
	opos_t     start_col;

	function automatic pos_t bump(pos_t v);
		return (v == {POS_BITS{1'b1}}) ? v : v + pos_t'(1);
	endfunction

	function automatic opos_t to_out(wide_t v);
		return (v > OUT_MAX) ? {OUT_BITS{1'b1}} : opos_t'(v);
	endfunction

	function automatic opos_t col_at(pos_t p);
		pos_t d;
		d = (p >= line_base) ? p - line_base : '0;
		return to_out(wide_t'(d) + wide_t'(1));
	endfunction

	function automatic logic blank(char_t c);
		return c == 16'h0020 || (c >= 16'h0009 && c <= 16'h000D) || c == 16'h0085 ||
			c == 16'h00A0 || c == 16'h1680 || (c >= 16'h2000 && c <= 16'h200A) ||
			c == 16'h2028 || c == 16'h2029 || c == 16'h202F || c == 16'h205F ||
			c == 16'h3000;
	endfunction

	task automatic clear_lexer();
		mode       = MODE_IDLE;
		char_pos   = '0;
		lines      = '0;
		line_base  = '0;
		start_line = '0;
		start_col  = opos_t'(1);
	endtask

	task automatic add_result(tok_kind_t kind, char_t c, logic cv, logic first, logic done,
		err_code_t err, opos_t line, opos_t col);
		if (batch_n < MAX_RES) begin
			batch[batch_n].kind       = kind;
			batch[batch_n].text       = cv ? c : '0;
			batch[batch_n].char_valid = cv;
			batch[batch_n].first      = first;
			batch[batch_n].done       = done;
			batch[batch_n].err        = err;
			batch[batch_n].line       = line;
			batch[batch_n].column     = col;
			batch_n++;
		end
	endtask

	task automatic between_tokens(char_t c, pos_t p);
		if (blank(c)) begin
			if (c == CH_NEWLINE) begin
				lines     = bump(lines);
				line_base = bump(p);
			end
		end else begin
			start_line = to_out(wide_t'(lines));
			start_col  = col_at(p);
			if (c == CH_LPAREN || c == CH_RPAREN) begin
				add_result(c == CH_LPAREN ? KIND_OPEN : KIND_CLOSE, c, 1'b1, 1'b1, 1'b1,
					ERR_NONE, start_line, start_col);
			end else if (c == CH_QUOTE) begin
				mode = MODE_STRING;
				add_result(KIND_STRING, '0, 1'b0, 1'b1, 1'b0, ERR_NONE, start_line, start_col);
			end else begin
				mode = MODE_IDENT;
				add_result(KIND_IDENT, c, 1'b1, 1'b1, 1'b0, ERR_NONE, start_line, start_col);
			end
		end
	endtask

	task automatic feed_char(char_t c, pos_t p);
		case (mode)
		MODE_IDLE: between_tokens(c, p);
		MODE_IDENT: begin
			if (blank(c) || c == CH_LPAREN || c == CH_RPAREN) begin
				add_result(KIND_IDENT, '0, 1'b0, 1'b0, 1'b1, ERR_NONE, start_line, start_col);
				mode = MODE_IDLE;
				between_tokens(c, p);
			end else begin
				add_result(KIND_IDENT, c, 1'b1, 1'b0, 1'b0, ERR_NONE, start_line, start_col);
			end
		end
		MODE_STRING: begin
			if (c == CH_BSLASH) begin
				mode = MODE_ESCAPE;
			end else if (c == CH_QUOTE) begin
				mode = MODE_IDLE;
				add_result(KIND_STRING, '0, 1'b0, 1'b0, 1'b1, ERR_NONE, start_line, start_col);
			end else begin
				add_result(KIND_STRING, c, 1'b1, 1'b0, 1'b0, ERR_NONE, start_line, start_col);
			end
		end
		MODE_ESCAPE: begin
			if (c == CH_QUOTE || c == CH_BSLASH || c == CH_LOWER_N) begin
				mode = MODE_STRING;
				add_result(KIND_STRING, (c == CH_LOWER_N) ? CH_NEWLINE : c, 1'b1, 1'b0, 1'b0,
					ERR_NONE, start_line, start_col);
			end else begin
				// bad escape is reported where the offending character sits
				mode = MODE_ERROR;
				add_result(KIND_ERROR, '0, 1'b0, 1'b1, 1'b1, ERR_ESCAPE,
					to_out(wide_t'(lines)), col_at(p));
			end
		end
		default: ;
		endcase
	endtask

	task automatic predict_tokens(char_t c, logic has, logic eol);
		token_beat_t beat;
		batch_n = 0;
		if (has) begin
			feed_char(c, char_pos);
			char_pos = bump(char_pos);
		end
		if (eol) begin
			if (mode == MODE_IDENT)
				add_result(KIND_IDENT, '0, 1'b0, 1'b0, 1'b1, ERR_NONE, start_line, start_col);
			else if (mode == MODE_STRING || mode == MODE_ESCAPE)
				add_result(KIND_ERROR, '0, 1'b0, 1'b1, 1'b1, ERR_UNCLOSED, start_line, start_col);
			clear_lexer();
		end
		for (int i = 0; i < batch_n; i++) begin
			beat.res  = batch[i];
			beat.last = (i == batch_n - 1);
			awaited.push_back(beat);
		end
	endtask

	task automatic report_mismatch(string msg);
		fail_cnt++;
		if (fail_cnt <= 50)
			$display("%0t: token result %0d: %s", $realtime, results_seen, msg);
	endtask

	task automatic check_field(string name, int unsigned got, int unsigned want);
		if (got != want)
			report_mismatch($sformatf("%s is %0h, expected %0h", name, got, want));
	endtask

	always @(posedge clk or negedge arst_n) begin
		token_beat_t want;
		if (!arst_n) begin
			clear_lexer();
			awaited.delete();
			backlog    <= 0;
			mismatches <= 0;
		end else begin
			if (m_tvalid && m_tready) begin
				if (awaited.size() == 0) begin
					report_mismatch("output transfer with no result expected");
				end else begin
					want = awaited.pop_front();
					check_field("token_kind", m_tuser[2:0], want.res.kind);
					check_field("text_char", m_tdata[15:0], want.res.text);
					check_field("char_valid", m_tuser[3], want.res.char_valid);
					check_field("token_first", m_tdata[16], want.res.first);
					check_field("token_done", m_tdata[17], want.res.done);
					check_field("error_code", m_tdata[19:18], want.res.err);
					check_field("line_no", m_tdata[35:20], want.res.line);
					check_field("column_no", m_tdata[51:36], want.res.column);
					check_field("run_last", m_tlast, want.last);
				end
				results_seen++;
			end
			if (s_tvalid && s_tready)
				predict_tokens(s_tdata, s_tuser, s_tlast);
			backlog    <= awaited.size();
			mismatches <= fail_cnt;
		end
	end

endmodule

@@ verif/s_expression_tokenizer_test.sv @@
// ----------------------------------------------------------------------------
// s_expression_tokenizer_test
// drives expression text into the tokenizer: directed corner cases, then
// random token sequences under varied back-pressure
// ----------------------------------------------------------------------------
module s_expression_tokenizer_test;
	timeunit 1ns;
	timeprecision 1ps;

	import sxt_pkg::*;

	localparam int QUIET_LIMIT = 2000;

	logic                      clk;
	logic                      arst_n;
	logic                      s_tvalid;
	logic                      s_tready;
	logic [15:0]               s_tdata;
	logic                      s_tuser;
	logic                      s_tlast;
	logic                      m_tvalid;
	logic                      m_tready = 1'b0;
	logic [OUT_TDATA_BITS-1:0] m_tdata;
	logic [OUT_TUSER_BITS-1:0] m_tuser;
	logic                      m_tlast;
	int                        mismatches;
	int                        backlog;

	int send_idle  = 0;
	int recv_stall = 0;
	int sent_units = 0;
	int quiet      = 0;

	char_t blanks [0:16] = '{16'h0009, 16'h000A, 16'h000B, 16'h000C, 16'h000D, 16'h0020,
		16'h0085, 16'h00A0, 16'h1680, 16'h2000, 16'h2005, 16'h200A, 16'h2028, 16'h2029,
		16'h202F, 16'h205F, 16'h3000};
	// neighbors of whitespace and escape letters that must not be treated as such
	char_t near_miss [0:13] = '{16'h0008, 16'h000E, 16'h001F, 16'h0021, 16'h0084, 16'h0086,
		16'h1FFF, 16'h200B, 16'h2027, 16'h202A, 16'h2FFF, 16'h3001, 16'h005B, 16'h006D};

	s_expression_tokenizer DUT (.*);

	s_expression_tokenizer_check checker_i (.*);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	always @(posedge clk) m_tready <= ($urandom_range(99) >= recv_stall);

	always @(posedge clk) begin
		if (!arst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
			quiet <= 0;
		end else if (quiet == QUIET_LIMIT) begin
			$display("s_expression_tokenizer_test failed");
			$finish;
		end else begin
			quiet <= quiet + 1;
		end
	end

	function automatic char_t pick_char();
		case ($urandom_range(3))
		0, 1: return char_t'($urandom_range(65535));
		2: return char_t'($urandom_range(126, 33));
		default: return near_miss[$urandom_range(13)];
		endcase
	endfunction

	task automatic send_unit(char_t ch, logic has, logic eol);
		while ($urandom_range(99) < send_idle) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= ch;
		s_tuser  <= has;
		s_tlast  <= eol;
		do @(posedge clk); while (!s_tready);
		sent_units++;
	endtask

	task automatic drain_results();
		s_tvalid <= 1'b0;
		do @(posedge clk); while (backlog != 0);
	endtask

	task automatic random_text(int n);
		int stop;
		int pick;
		int sel;
		stop = sent_units + n;
		while (sent_units < stop) begin
			pick = $urandom_range(99);
			if (pick < 20) begin
				send_unit(pick[0] ? CH_LPAREN : CH_RPAREN, 1'b1, 1'b0);
			end else if (pick < 45) begin
				repeat ($urandom_range(4, 1)) send_unit(pick_char(), 1'b1, 1'b0);
			end else if (pick < 68) begin
				send_unit(CH_QUOTE, 1'b1, 1'b0);
				repeat ($urandom_range(4)) begin
					if ($urandom_range(99) < 25) begin
						send_unit(CH_BSLASH, 1'b1, 1'b0);
						sel = $urandom_range(9);
						send_unit(sel == 0 ? pick_char() : sel < 4 ? CH_QUOTE :
							sel < 7 ? CH_BSLASH : CH_LOWER_N, 1'b1, 1'b0);
					end else begin
						send_unit(pick_char(), 1'b1, 1'b0);
					end
				end
				// now and then the string is left open
				if ($urandom_range(9) != 0)
					send_unit(CH_QUOTE, 1'b1, 1'b0);
			end else if (pick < 85) begin
				send_unit(blanks[$urandom_range(16)], 1'b1, 1'b0);
			end else if (pick < 93) begin
				send_unit(pick_char(), 1'($urandom_range(1)), 1'b1);
			end else begin
				send_unit(pick_char(), 1'b0, 1'b0);
			end
		end
	endtask

	initial begin
		arst_n   = 1'b0;
		s_tvalid = 1'b0;
		s_tdata  = '0;
		s_tuser  = 1'b0;
		s_tlast  = 1'b0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// parens, identifier with extreme code units closed by a paren
		send_unit(CH_LPAREN, 1'b1, 1'b0);
		send_unit(16'hFFFF, 1'b1, 1'b0);
		send_unit(16'h0000, 1'b1, 1'b0);
		send_unit(CH_RPAREN, 1'b1, 1'b0);
		send_unit(CH_NEWLINE, 1'b1, 1'b0);
		// string with all three escapes
		send_unit(CH_QUOTE, 1'b1, 1'b0);
		send_unit(CH_BSLASH, 1'b1, 1'b0);
		send_unit(CH_LOWER_N, 1'b1, 1'b0);
		send_unit(CH_BSLASH, 1'b1, 1'b0);
		send_unit(CH_BSLASH, 1'b1, 1'b0);
		send_unit(CH_BSLASH, 1'b1, 1'b0);
		send_unit(CH_QUOTE, 1'b1, 1'b0);
		send_unit(16'h0041, 1'b1, 1'b0);
		send_unit(CH_QUOTE, 1'b1, 1'b0);
		send_unit(16'h3000, 1'b1, 1'b0);
		// identifier closed by the end of the expression
		send_unit(16'h0078, 1'b1, 1'b1);
		// bad escape, then ignored input until a bare end marker
		send_unit(CH_QUOTE, 1'b1, 1'b0);
		send_unit(CH_BSLASH, 1'b1, 1'b0);
		send_unit(16'h0071, 1'b1, 1'b0);
		send_unit(CH_RPAREN, 1'b1, 1'b0);
		send_unit(16'h0000, 1'b0, 1'b0);
		send_unit(16'hFFFF, 1'b0, 1'b1);
		// unclosed string, once right after a backslash
		send_unit(CH_QUOTE, 1'b1, 1'b0);
		send_unit(CH_BSLASH, 1'b1, 1'b1);
		send_unit(CH_QUOTE, 1'b1, 1'b0);
		send_unit(16'h0061, 1'b1, 1'b1);
		drain_results();

		random_text(50);
		drain_results();

		send_idle = 77;
		random_text(50);

		send_idle  = 0;
		recv_stall = 77;
		random_text(50);

		send_idle  = 35;
		recv_stall = 35;
		random_text(50);

		drain_results();
		repeat (10) @(posedge clk);
		if (mismatches == 0)
			$display("s_expression_tokenizer_test passed");
		else
			$display("s_expression_tokenizer_test failed");
		$finish;
	end

endmodule
